// ===== src/dswrp_pkg.sv =====
package dswrp_pkg;

  // Set capacity and derived widths.
  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 32;
  localparam int RW_W      = 31;
  localparam int DIV_CNT_W = $clog2(RW_W + 1);

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PICK   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_FIX
  } state_t;

  // Per-cell control: rotate the ring, and replace the wrapping entry.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== src/dswrp_cell.sv =====
module dswrp_cell (
  input  logic                                clk,
  input  dswrp_pkg::cell_ctrl_t               ctrl,
  input  logic signed [dswrp_pkg::VAL_W-1:0]  nb_value,
  input  logic signed [dswrp_pkg::VAL_W-1:0]  load_value,
  output logic signed [dswrp_pkg::VAL_W-1:0]  value
);

  logic signed [dswrp_pkg::VAL_W-1:0] value_r;
  logic signed [dswrp_pkg::VAL_W-1:0] value_nxt;

  // Take the neighbor's entry on a shift, or the replacement data on a shift with load.
  always_comb begin
    value_nxt = value_r;
    if (ctrl.shift) begin
      value_nxt = ctrl.load ? load_value : nb_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== src/dswrp_div.sv =====
module dswrp_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [dswrp_pkg::RW_W-1:0]       dividend,
  input  logic [dswrp_pkg::CNT_W-1:0]      divisor,
  output logic                             done,
  output logic [dswrp_pkg::IDX_W-1:0]      remainder
);

  logic                              active_r, active_nxt;
  logic                              done_r, done_nxt;
  logic [dswrp_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [dswrp_pkg::RW_W-1:0]        quo_r, quo_nxt;
  logic [dswrp_pkg::CNT_W-1:0]       dsr_r, dsr_nxt;
  logic [dswrp_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic [dswrp_pkg::CNT_W:0]         trial;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    dsr_nxt    = dsr_r;
    rem_nxt    = rem_r;
    trial      = {rem_r, quo_r[dswrp_pkg::RW_W-1]};
    if (start && !active_r) begin
      active_nxt = 1'b1;
      cnt_nxt    = dswrp_pkg::DIV_CNT_W'(dswrp_pkg::RW_W);
      quo_nxt    = dividend;
      dsr_nxt    = divisor;
      rem_nxt    = '0;
    end else if (active_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = dswrp_pkg::CNT_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = dswrp_pkg::CNT_W'(trial);
      end
      quo_nxt = {quo_r[dswrp_pkg::RW_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dswrp_pkg::DIV_CNT_W'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  // The remainder is below the divisor, which is at most the capacity.
  assign done      = done_r;
  assign remainder = rem_r[dswrp_pkg::IDX_W-1:0];

endmodule

// ===== src/dense_set_with_random_pick.sv =====
// Channel   Ports                                          Handshake
// request   in_operation, in_value, in_random_word         start && !busy
// result    out_success, out_status, out_picked_value      out_valid, one cycle
//
// Insert, or remove of an absent value: one ring turn. Remove of a present
// value: a search turn, then a write-back turn. Pick: accept, the divider
// steps through the random word, a hand-off, then one ring turn. Empty pick
// and unused codes are answered from the idle state without a ring turn.
// Reset (rst_n low, synchronous) empties the set; entries are not cleared.
// The result receiver cannot stall; each result shows for one cycle.
module dense_set_with_random_pick (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic signed [dswrp_pkg::VAL_W-1:0]  in_value,
  input  logic [dswrp_pkg::RW_W-1:0]          in_random_word,
  output logic                                out_valid,
  output logic                                out_success,
  output logic [1:0]                          out_status,
  output logic signed [dswrp_pkg::VAL_W-1:0]  out_picked_value
);

  dswrp_pkg::state_t                   state_r, state_nxt;
  logic [1:0]                          op_r, op_nxt;
  logic signed [dswrp_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic [dswrp_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [dswrp_pkg::IDX_W-1:0]         step_r, step_nxt;
  logic                                found_r, found_nxt;
  logic [dswrp_pkg::IDX_W-1:0]         pos_r, pos_nxt;
  logic signed [dswrp_pkg::VAL_W-1:0]  last_r, last_nxt;
  logic [dswrp_pkg::IDX_W-1:0]         pick_pos_r, pick_pos_nxt;
  logic signed [dswrp_pkg::VAL_W-1:0]  picked_r, picked_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_success_r, out_success_nxt;
  logic [1:0]                          out_status_r, out_status_nxt;
  logic signed [dswrp_pkg::VAL_W-1:0]  out_picked_r, out_picked_nxt;

  logic                                div_start;
  logic                                div_done;
  logic [dswrp_pkg::IDX_W-1:0]         div_rem;

  dswrp_pkg::cell_ctrl_t               cell_ctrl [dswrp_pkg::CAPACITY];
  logic signed [dswrp_pkg::VAL_W-1:0]  cell_value [dswrp_pkg::CAPACITY];
  logic signed [dswrp_pkg::VAL_W-1:0]  load_value;
  logic                                ring_shift;
  logic                                ring_load;

  logic signed [dswrp_pkg::VAL_W-1:0]  head;
  logic [dswrp_pkg::CNT_W-1:0]         step_ext;
  logic                                hit;
  logic                                last_step;
  logic                                found_all;

  // Ring of cells: cell 0 is the head, each cell takes its upper neighbor, the last cell takes cell 0.
  for (genvar i = 0; i < dswrp_pkg::CAPACITY; i++) begin : g_cell
    if (i == dswrp_pkg::CAPACITY - 1) begin : g_tail
      assign cell_ctrl[i] = '{shift: ring_shift, load: ring_load};
      dswrp_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .nb_value   (cell_value[0]),
        .load_value (load_value),
        .value      (cell_value[i])
      );
    end else begin : g_body
      assign cell_ctrl[i] = '{shift: ring_shift, load: 1'b0};
      dswrp_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .nb_value   (cell_value[i+1]),
        .load_value (load_value),
        .value      (cell_value[i])
      );
    end
  end

  // Pick position is the random word modulo the member count.
  dswrp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_random_word),
    .divisor   (count_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // The entry at position step_r sits in the head cell during a ring turn.
  assign head      = cell_value[0];
  assign step_ext  = dswrp_pkg::CNT_W'(step_r);
  assign hit       = (step_ext < count_r) && (head == value_r) && !found_r;
  assign last_step = (step_r == dswrp_pkg::IDX_W'(dswrp_pkg::CAPACITY - 1));
  assign found_all = found_r || hit;

  // Request sequencing and result formation.
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    value_nxt       = value_r;
    count_nxt       = count_r;
    step_nxt        = step_r;
    found_nxt       = found_r;
    pos_nxt         = pos_r;
    last_nxt        = last_r;
    pick_pos_nxt    = pick_pos_r;
    picked_nxt      = picked_r;
    out_valid_nxt   = 1'b0;
    out_success_nxt = out_success_r;
    out_status_nxt  = out_status_r;
    out_picked_nxt  = out_picked_r;
    div_start       = 1'b0;
    ring_shift      = 1'b0;
    ring_load       = 1'b0;
    load_value      = value_r;
    case (state_r)
      dswrp_pkg::S_IDLE: begin
        if (start) begin
          op_nxt         = in_operation;
          value_nxt      = in_value;
          step_nxt       = '0;
          found_nxt      = 1'b0;
          out_picked_nxt = '1;
          if (in_operation == dswrp_pkg::OP_INSERT ||
              in_operation == dswrp_pkg::OP_REMOVE) begin
            state_nxt = dswrp_pkg::S_SCAN;
          end else if (in_operation == dswrp_pkg::OP_PICK) begin
            if (count_r == '0) begin
              out_valid_nxt   = 1'b1;
              out_success_nxt = 1'b0;
              out_status_nxt  = dswrp_pkg::ST_EMPTY;
            end else begin
              div_start = 1'b1;
              state_nxt = dswrp_pkg::S_DIV;
            end
          end else begin
            out_valid_nxt   = 1'b1;
            out_success_nxt = 1'b0;
            out_status_nxt  = dswrp_pkg::ST_OK;
          end
        end
      end
      dswrp_pkg::S_DIV: begin
        if (div_done) begin
          pick_pos_nxt = div_rem;
          state_nxt    = dswrp_pkg::S_SCAN;
        end
      end
      dswrp_pkg::S_SCAN: begin
        ring_shift = 1'b1;
        step_nxt   = step_r + 1'b1;
        found_nxt  = found_all;
        if (hit) begin
          pos_nxt = step_r;
        end
        if (step_ext + 1'b1 == count_r) begin
          last_nxt = head;
        end
        if (step_r == pick_pos_r) begin
          picked_nxt = head;
        end
        // Append an absent value as the entry just past the last member.
        if (op_r == dswrp_pkg::OP_INSERT && !found_r && step_ext == count_r) begin
          ring_load = 1'b1;
        end
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = dswrp_pkg::S_IDLE;
          out_picked_nxt = '1;
          case (op_r)
            dswrp_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (found_all) begin
                out_success_nxt = 1'b0;
                out_status_nxt  = dswrp_pkg::ST_CONFLICT;
              end else if (count_r == dswrp_pkg::CNT_W'(dswrp_pkg::CAPACITY)) begin
                out_success_nxt = 1'b0;
                out_status_nxt  = dswrp_pkg::ST_FULL;
              end else begin
                out_success_nxt = 1'b1;
                out_status_nxt  = dswrp_pkg::ST_OK;
                count_nxt       = count_r + 1'b1;
              end
            end
            dswrp_pkg::OP_REMOVE: begin
              if (found_all) begin
                state_nxt = dswrp_pkg::S_FIX;
              end else begin
                out_valid_nxt   = 1'b1;
                out_success_nxt = 1'b0;
                out_status_nxt  = dswrp_pkg::ST_CONFLICT;
              end
            end
            default: begin
              out_valid_nxt   = 1'b1;
              out_success_nxt = 1'b1;
              out_status_nxt  = dswrp_pkg::ST_OK;
              out_picked_nxt  = (step_r == pick_pos_r) ? head : picked_r;
            end
          endcase
        end
      end
      dswrp_pkg::S_FIX: begin
        // Second turn: the last member overwrites the removed one.
        ring_shift = 1'b1;
        load_value = last_r;
        ring_load  = (step_r == pos_r);
        step_nxt   = step_r + 1'b1;
        if (last_step) begin
          step_nxt        = '0;
          state_nxt       = dswrp_pkg::S_IDLE;
          count_nxt       = count_r - 1'b1;
          out_valid_nxt   = 1'b1;
          out_success_nxt = 1'b1;
          out_status_nxt  = dswrp_pkg::ST_OK;
          out_picked_nxt  = '1;
        end
      end
      default: begin
        state_nxt = dswrp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dswrp_pkg::S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    value_r       <= value_nxt;
    pos_r         <= pos_nxt;
    last_r        <= last_nxt;
    pick_pos_r    <= pick_pos_nxt;
    picked_r      <= picked_nxt;
    out_success_r <= out_success_nxt;
    out_status_r  <= out_status_nxt;
    out_picked_r  <= out_picked_nxt;
  end

  assign busy             = (state_r != dswrp_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_success      = out_success_r;
  assign out_status       = out_status_r;
  assign out_picked_value = out_picked_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dswrp_pkg::CNT_W'(dswrp_pkg::CAPACITY))
    else $error("member count exceeds capacity");

  a_count_moves_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(busy) && !busy && out_valid)
    else $error("member count changed outside the end of a request");

  a_success_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_success) |-> (out_status == dswrp_pkg::ST_OK))
    else $error("successful result with a non-ok status");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == dswrp_pkg::S_DIV))
    else $error("divider finished outside the divide state");

  a_fix_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == dswrp_pkg::S_FIX) |->
      ($past(state_r) == dswrp_pkg::S_SCAN) && (op_r == dswrp_pkg::OP_REMOVE) && found_r)
    else $error("write-back turn entered without a found remove");
`endif

endmodule
